>>> rtl/base64_stream_encoder_assert.svh
// Assertion macros used by the checker module of the Base64 encoder.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define B64_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define B64_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/b64enc_pkg.sv
package b64enc_pkg;

    // Number of message bytes present in a three-byte group (1 to 3).
    typedef logic [1:0] nbytes_t;

    localparam nbytes_t NB_ONE   = 2'd1;
    localparam nbytes_t NB_TWO   = 2'd2;
    localparam nbytes_t NB_THREE = 2'd3;

    // Position of a character within the four emitted for a group.
    typedef logic [1:0] char_idx_t;

    localparam char_idx_t CHAR_FIRST  = 2'd0;
    localparam char_idx_t CHAR_SECOND = 2'd1;
    localparam char_idx_t CHAR_THIRD  = 2'd2;
    localparam char_idx_t CHAR_LAST   = 2'd3;

    // ASCII code of the padding character '='.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // One group handed from the front end to the back end.
    typedef struct packed {
        logic [23:0] bits;
        nbytes_t     nbytes;
    } grp_t;

    // Maps a six-bit index onto the standard alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'd65;
        end else if (v < 6'd52) begin
            return w + 8'd71;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

>>> rtl/b64enc_front.sv
module b64enc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_message
    input  logic                 q_full,
    output logic                 q_push,
    output b64enc_pkg::grp_t     q_entry
);

    logic [15:0]         held_reg;
    logic [15:0]         held_next;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                accept;
    b64enc_pkg::grp_t    grp;

    // A byte is taken whenever the queue has room for a possible group.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Assemble the group that this byte completes or starts.
    always_comb begin
        case (count_reg)
            b64enc_pkg::NB_TWO: begin
                grp.bits   = {held_reg, s_tdata};
                grp.nbytes = b64enc_pkg::NB_THREE;
            end
            b64enc_pkg::NB_ONE: begin
                grp.bits   = {held_reg[7:0], s_tdata, 8'h00};
                grp.nbytes = b64enc_pkg::NB_TWO;
            end
            default: begin
                grp.bits   = {s_tdata, 16'h0000};
                grp.nbytes = b64enc_pkg::NB_ONE;
            end
        endcase
    end

    // A full group or the end of a message goes into the queue.
    assign q_push  = accept && (grp.nbytes == b64enc_pkg::NB_THREE || s_tlast);
    assign q_entry = grp;

    // Update the pending bytes.
    always_comb begin
        held_next  = held_reg;
        count_next = count_reg;
        if (q_push) begin
            held_next  = '0;
            count_next = '0;
        end else if (accept) begin
            held_next  = {held_reg[7:0], s_tdata};
            count_next = grp.nbytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            count_reg <= '0;
        end else begin
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/b64enc_queue.sv
module b64enc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  b64enc_pkg::grp_t     push_entry,
    output logic                 full,
    input  logic                 pop,
    output b64enc_pkg::grp_t     pop_entry,
    output logic                 empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

    b64enc_pkg::grp_t    mem [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg;
    logic [PW-1:0]       rd_ptr_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    assign full      = (count_reg == COUNT_MAX);
    assign empty     = (count_reg == '0);
    assign pop_entry = mem[rd_ptr_reg];

    // Pointer and fill-level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for the queued groups.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/b64enc_back.sv
module b64enc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  b64enc_pkg::grp_t     q_entry,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_char
    output logic                 m_tlast    // last_of_run
);

    logic                      busy_reg;
    logic                      busy_next;
    b64enc_pkg::char_idx_t     idx_reg;
    b64enc_pkg::char_idx_t     idx_next;
    b64enc_pkg::grp_t          grp_reg;
    logic                      valid_reg;
    logic                      valid_next;
    logic [7:0]                data_reg;
    logic [7:0]                data_next;
    logic                      last_reg;
    logic                      last_next;
    logic                      adv;
    logic                      load;
    logic [5:0]                sextet;
    logic                      pad;

    // The output register is free when empty or being taken this cycle.
    assign adv  = busy_reg && (!valid_reg || m_tready);
    assign load = !q_empty && (!busy_reg || (adv && idx_reg == b64enc_pkg::CHAR_LAST));
    assign q_pop = load;

    // Pick the six bits for the current character, most significant first.
    always_comb begin
        case (idx_reg)
            b64enc_pkg::CHAR_FIRST:  sextet = grp_reg.bits[23:18];
            b64enc_pkg::CHAR_SECOND: sextet = grp_reg.bits[17:12];
            b64enc_pkg::CHAR_THIRD:  sextet = grp_reg.bits[11:6];
            default:                 sextet = grp_reg.bits[5:0];
        endcase
    end

    // Short groups end in one or two padding characters.
    assign pad = (idx_reg == b64enc_pkg::CHAR_THIRD && grp_reg.nbytes == b64enc_pkg::NB_ONE)
              || (idx_reg == b64enc_pkg::CHAR_LAST && grp_reg.nbytes != b64enc_pkg::NB_THREE);

    // Character sequencing and output register.
    always_comb begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (adv) begin
            valid_next = 1'b1;
            data_next  = pad ? b64enc_pkg::PAD_CHAR : b64enc_pkg::b64_char(sextet);
            last_next  = (idx_reg == b64enc_pkg::CHAR_LAST);
            idx_next   = idx_reg + 1'b1;
            if (idx_reg == b64enc_pkg::CHAR_LAST) begin
                busy_next = 1'b0;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            busy_next = 1'b1;
            idx_next  = b64enc_pkg::CHAR_FIRST;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= b64enc_pkg::CHAR_FIRST;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        if (load) begin
            grp_reg <= q_entry;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/base64_stream_encoder.sv
// Channel   Direction  Payload
// s_        in         tdata[7:0] data_byte, tlast end_of_message
// m_        out        tdata[7:0] out_char,  tlast last_of_run
//
// A byte is taken in every cycle while the group queue has room; a byte that
// completes a group or ends a message queues that group.
// Each group leaves as four characters, one per cycle while the sink accepts
// them, so the character sequencer sets the sustained rate.
// The first character of a group passes the queue, the group register and the output register.
// Reset (aresetn low at a clock edge) clears the pending bytes and the queue.
// Either side may stall without loss; the queue and output register absorb it.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast    // last_of_run
);

    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;
    b64enc_pkg::grp_t    push_entry;
    b64enc_pkg::grp_t    pop_entry;

    // Front end: gathers bytes into groups.
    b64enc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // Queue of groups waiting for the character sequencer.
    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    // Back end: emits four characters per group.
    b64enc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/b64enc_checker.sv
`include "base64_stream_encoder_assert.svh"

module b64enc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_char
    input  logic        m_tlast    // last_of_run
);

    b64enc_pkg::char_idx_t pos_reg;
    logic                  pad_reg;
    logic                  m_xfer;

    assign m_xfer = m_tvalid && m_tready;

    // Track the position of each output character within its group.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= b64enc_pkg::CHAR_FIRST;
            pad_reg <= 1'b0;
        end else if (m_xfer) begin
            pos_reg <= pos_reg + 1'b1;
            pad_reg <= (m_tdata == b64enc_pkg::PAD_CHAR) && !m_tlast;
        end
    end

    // A stalled character must hold.
    `B64_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

    // Every group is exactly four characters, the fourth one marked last.
    `B64_ASSERT_NOW(a_tlast_pos, aclk, aresetn, m_xfer,
        m_tlast == (pos_reg == b64enc_pkg::CHAR_LAST),
        "tlast not on the fourth character of a group")

    // The first two characters of a group are never padding.
    `B64_ASSERT_NOW(a_no_early_pad, aclk, aresetn,
        m_xfer && (pos_reg == b64enc_pkg::CHAR_FIRST || pos_reg == b64enc_pkg::CHAR_SECOND),
        m_tdata != b64enc_pkg::PAD_CHAR, "padding in the first half of a group")

    // Padding in the third place is followed by padding in the fourth.
    `B64_ASSERT_NOW(a_pad_pair, aclk, aresetn,
        m_xfer && pos_reg == b64enc_pkg::CHAR_LAST && pad_reg,
        m_tdata == b64enc_pkg::PAD_CHAR, "single padding character after a padded third")

endmodule

bind base64_stream_encoder b64enc_checker u_checker (.*);

>>> tb/sv/base64_stream_encoder_check.sv
// Watches both channels of the encoder, predicts the Base64 text for every
// accepted byte and compares each character transfer with the oldest
// prediction still outstanding.
module base64_stream_encoder_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_message
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_char
    input  logic        m_tlast,   // last_of_run
    output int          fail_count,
    output int          chars_pending,
    output int          chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Standard alphabet, index 0 in the top byte.
    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] code;
        logic       ends_run;
    } b64_char_t;

    // Characters still owed by the encoder, oldest first.
    b64_char_t             owed_text[$];

    // Our own copy of the bytes waiting for a full group.
    logic [15:0]           pend_bytes;
    b64enc_pkg::nbytes_t   pend_count;

    function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
        return ALPHABET[8 * (63 - idx) +: 8];
    endfunction

    // Adds one byte to the group and queues the characters it releases.
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        logic [23:0]         grp;
        b64enc_pkg::nbytes_t nb;
        b64_char_t           c;
        if (pend_count == b64enc_pkg::NB_TWO) begin
            grp = {pend_bytes, b};
            nb  = b64enc_pkg::NB_THREE;
        end else if (pend_count == b64enc_pkg::NB_ONE) begin
            grp = {pend_bytes[7:0], b, 8'h00};
            nb  = b64enc_pkg::NB_TWO;
        end else begin
            grp = {b, 16'h0000};
            nb  = b64enc_pkg::NB_ONE;
        end

        if (nb != b64enc_pkg::NB_THREE && !eom) begin
            // Partial group in mid-message: hold the byte, nothing leaves.
            pend_bytes = (nb == b64enc_pkg::NB_ONE) ? {8'h00, b} : {pend_bytes[7:0], b};
            pend_count = nb;
        end else begin
            c.ends_run = 1'b0;
            c.code = alphabet_char(grp[23:18]);
            owed_text = {owed_text, c};
            c.code = alphabet_char(grp[17:12]);
            owed_text = {owed_text, c};
            c.code = (nb == b64enc_pkg::NB_ONE) ? b64enc_pkg::PAD_CHAR
                                                : alphabet_char(grp[11:6]);
            owed_text = {owed_text, c};
            c.ends_run = 1'b1;
            c.code = (nb == b64enc_pkg::NB_THREE) ? alphabet_char(grp[5:0])
                                                  : b64enc_pkg::PAD_CHAR;
            owed_text = {owed_text, c};
            pend_bytes = '0;
            pend_count = '0;
        end
    endtask

    // Character transfers are checked before the byte of the same edge is
    // predicted; a byte can never produce a character at its own edge.
    always @(posedge aclk) begin
        b64_char_t want;
        if (!aresetn) begin
            owed_text.delete();
            pend_bytes    = '0;
            pend_count    = '0;
            fail_count    = 0;
            chars_checked = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_text.size() == 0) begin
                    $display("%0t: unexpected character transfer, expected none, %s",
                             $time, $sformatf("got %02h last %b", m_tdata, m_tlast));
                    fail_count++;
                end else begin
                    want = owed_text.pop_front();
                    chars_checked++;
                    if (m_tdata !== want.code) begin
                        $display("%0t: out_char expected %02h got %02h",
                                 $time, want.code, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.ends_run) begin
                        $display("%0t: last_of_run expected %b got %b",
                                 $time, want.ends_run, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
        end
        chars_pending = owed_text.size();
    end

endmodule

>>> tb/sv/base64_stream_encoder_test.sv
// Top of the encoder bench: clock, reset, byte stimulus, character sink,
// watchdog and verdict. Checking lives in base64_stream_encoder_check.
module base64_stream_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GAP        = 16;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TARGET_BYTES   = 100;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;   // end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_char
    logic        m_tlast;   // last_of_run

    int          fail_count;
    int          chars_pending;
    int          chars_checked;

    int          bytes_sent;
    int          messages_sent;
    bit          tx_eager;
    bit          rx_eager;
    bit          rx_hold_req;

    base64_stream_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    base64_stream_encoder_check checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .chars_pending (chars_pending),
        .chars_checked (chars_checked)
    );

    // 10 ns clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offers one byte after a random gap and waits for its transfer.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 31) == 0)
            tx_eager = !tx_eager;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (eom)
            messages_sent++;
    endtask

    // Sends a message of len bytes; a few messages are all zeros or all ones.
    task automatic send_message(input int len);
        int         fill;
        logic [7:0] b;
        fill = $urandom_range(0, 9);
        for (int i = 0; i < len; i++) begin
            case (fill)
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // Stops offering and waits until every owed character has arrived.
    task automatic drain_output();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (chars_pending != 0)
            @(negedge aclk);
    endtask

    // Character sink: random stalls per transfer, with eager stretches and,
    // once on request, a long hold that backs the encoder up.
    initial begin
        int gap;
        bit hold_taken;
        m_tready   = 1'b0;
        rx_eager   = 1'b0;
        hold_taken = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 31) == 0)
                rx_eager = !rx_eager;
            if (rx_hold_req && !hold_taken) begin
                gap        = RX_HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("base64_stream_encoder regression: fail");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        bit hold_done;
        bit drain_done;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        s_tlast       = 1'b0;
        aresetn       = 1'b0;
        bytes_sent    = 0;
        messages_sent = 0;
        tx_eager      = 1'b0;
        rx_hold_req   = 1'b0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // One byte ending a message, both extremes: two characters and "==".
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // Two bytes ending a message: three characters and "=".
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Group completed by the final byte itself.
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // Group completed mid-message, hitting '+' and '/', then one byte left.
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b1);
        // Full group with high bytes, then a two-byte tail.
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h3E, 1'b0);
        send_byte(8'hFC, 1'b1);
        // Two bytes held, third one ends the message.
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b1);

        // Random messages of mostly short length.
        while (bytes_sent < TARGET_BYTES) begin
            if (!hold_done && bytes_sent >= 45) begin
                // Sink holds off while bytes keep coming back to back.
                rx_hold_req = 1'b1;
                tx_eager    = 1'b1;
                send_message(15);
                tx_eager    = 1'b0;
                hold_done   = 1'b1;
            end else if (!drain_done && bytes_sent >= 75) begin
                drain_output();
                drain_done = 1'b1;
            end else begin
                send_message($urandom_range(0, 5) == 0 ? $urandom_range(7, 14)
                                                       : $urandom_range(1, 6));
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (chars_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Encoded %0d messages from %0d bytes; %0d characters compared.",
                 messages_sent, bytes_sent, chars_checked);
        $display("Included a %0d-cycle sink hold and a full drain pause.", RX_HOLD_CYCLES);
        if (fail_count == 0)
            $display("base64_stream_encoder regression: pass");
        else
            $display("base64_stream_encoder regression: fail");
        $finish;
    end

endmodule
